### hw/rtl/ece_pkg.sv
// ----------------------------------------------------------------------------
// ece_pkg: shared types for the easing curve evaluator
// Curve selector codes, the decoded curve kind and order, and the decoder.
// ----------------------------------------------------------------------------
package ece_pkg;

    localparam int CMD_W  = 4;
    localparam int TIME_W = 16;

    // Curve selector codes as they arrive on the input channel
    localparam logic [CMD_W-1:0] CMD_QUAD_IN     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_QUAD_OUT    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_QUAD_BOTH   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CUBIC_IN    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_CUBIC_OUT   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CUBIC_BOTH  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_QUART_IN    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_QUART_OUT   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_QUART_BOTH  = 4'd8;

    // Shape of the curve; KIND_OFF yields a zero curve
    typedef enum logic [1:0] {
        KIND_IN   = 2'd0,
        KIND_OUT  = 2'd1,
        KIND_BOTH = 2'd2,
        KIND_OFF  = 2'd3
    } ease_kind_t;

    // Polynomial order: square, cube, fourth power
    typedef enum logic [1:0] {
        ORDER_QUAD  = 2'd0,
        ORDER_CUBIC = 2'd1,
        ORDER_QUART = 2'd2
    } ease_order_t;

    typedef struct packed {
        ease_kind_t  kind;
        ease_order_t order;
    } ease_sel_t;

    // Split a selector code into kind and order
    function automatic ease_sel_t decode_cmd(logic [CMD_W-1:0] cmd);
        ease_sel_t sel;
        sel.kind  = KIND_OFF;
        sel.order = ORDER_QUAD;
        case (cmd)
            CMD_QUAD_IN:    begin sel.kind = KIND_IN;   sel.order = ORDER_QUAD;  end
            CMD_QUAD_OUT:   begin sel.kind = KIND_OUT;  sel.order = ORDER_QUAD;  end
            CMD_QUAD_BOTH:  begin sel.kind = KIND_BOTH; sel.order = ORDER_QUAD;  end
            CMD_CUBIC_IN:   begin sel.kind = KIND_IN;   sel.order = ORDER_CUBIC; end
            CMD_CUBIC_OUT:  begin sel.kind = KIND_OUT;  sel.order = ORDER_CUBIC; end
            CMD_CUBIC_BOTH: begin sel.kind = KIND_BOTH; sel.order = ORDER_CUBIC; end
            CMD_QUART_IN:   begin sel.kind = KIND_IN;   sel.order = ORDER_QUART; end
            CMD_QUART_OUT:  begin sel.kind = KIND_OUT;  sel.order = ORDER_QUART; end
            CMD_QUART_BOTH: begin sel.kind = KIND_BOTH; sel.order = ORDER_QUART; end
            default:        begin sel.kind = KIND_OFF;  sel.order = ORDER_QUAD;  end
        endcase
        return sel;
    endfunction

endpackage

### hw/rtl/ece_div.sv
// ----------------------------------------------------------------------------
// ece_div: pipelined fraction divider
// Forms u = min(elapsed, duration) * 2^FRAC_BITS / duration, one quotient
// bit per stage, restoring compare and subtract.
// ----------------------------------------------------------------------------
module ece_div
    import ece_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ease_sel_t             in_sel,
    input  logic [TIME_W-1:0]     in_elapsed,
    input  logic [TIME_W-1:0]     in_duration,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ease_sel_t             out_sel,
    output logic [FRAC_BITS:0]    out_u,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int LAST = FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic                 vld_reg  [0:LAST];
    logic                 adv      [0:LAST];
    ease_sel_t            sel_reg  [0:LAST];
    logic [SIDE_W-1:0]    side_reg [0:LAST];
    logic                 sat_reg  [0:LAST];
    logic [TIME_W-1:0]    rem_reg  [0:LAST];
    logic [TIME_W-1:0]    dvs_reg  [0:LAST];
    logic [FRAC_BITS-1:0] quo_reg  [0:LAST];

    logic sat_next;

    // Advance a stage when it is empty or the next one advances
    genvar gi;
    generate
        for (gi = 0; gi < LAST; gi++) begin : g_adv
            assign adv[gi] = !vld_reg[gi] || adv[gi+1];
        end
    endgenerate
    assign adv[LAST] = !vld_reg[LAST] || out_ready;

    // Fraction is one when the tween is over or has no length
    assign sat_next = (in_duration == '0) || (in_elapsed >= in_duration);

    // Entry stage: capture operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv[0])
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sel_reg[0]  <= in_sel;
            side_reg[0] <= in_side;
            sat_reg[0]  <= sat_next;
            rem_reg[0]  <= in_elapsed;
            dvs_reg[0]  <= in_duration;
            quo_reg[0]  <= '0;
        end
    end

    // Quotient stages: one bit each, most significant first
    generate
        for (gi = 1; gi <= LAST; gi++) begin : g_step
            logic [TIME_W:0]      dbl;
            logic [TIME_W:0]      dif;
            logic                 ge;
            logic [TIME_W-1:0]    rem_next;
            logic [FRAC_BITS-1:0] quo_next;

            always_comb
            begin
                dbl      = {rem_reg[gi-1], 1'b0};
                dif      = dbl - {1'b0, dvs_reg[gi-1]};
                ge       = (dbl >= {1'b0, dvs_reg[gi-1]});
                rem_next = ge ? dif[TIME_W-1:0] : dbl[TIME_W-1:0];
                quo_next = {quo_reg[gi-1][FRAC_BITS-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[gi] <= 1'b0;
                end
                else if (adv[gi])
                begin
                    vld_reg[gi] <= vld_reg[gi-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[gi])
                begin
                    sel_reg[gi]  <= sel_reg[gi-1];
                    side_reg[gi] <= side_reg[gi-1];
                    sat_reg[gi]  <= sat_reg[gi-1];
                    rem_reg[gi]  <= rem_next;
                    dvs_reg[gi]  <= dvs_reg[gi-1];
                    quo_reg[gi]  <= quo_next;
                end
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[LAST];
    assign out_sel   = sel_reg[LAST];
    assign out_side  = side_reg[LAST];
    assign out_u     = sat_reg[LAST] ? ONE : {1'b0, quo_reg[LAST]};

endmodule

### hw/rtl/ece_curve.sv
// ----------------------------------------------------------------------------
// ece_curve: easing curve shaper
// Mirrors the fraction as the curve needs, raises it to the second, third
// and fourth power one multiply per stage, then scales and clamps.
// ----------------------------------------------------------------------------
module ece_curve
    import ece_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ease_sel_t          in_sel,
    input  logic [FRAC_BITS:0] in_u,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FRAC_BITS:0] out_c,
    output logic [SIDE_W-1:0]  out_side
);

    localparam int NSTG  = 5;
    localparam int QW    = FRAC_BITS + 1;
    localparam int SW    = FRAC_BITS + 4;
    localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] HALF = QW'(1) << (FRAC_BITS - 1);
    localparam logic [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

    // Rounded fixed-point product of two fractions in [0, ONE]
    function automatic logic [QW-1:0] qmul(logic [QW-1:0] a, logic [QW-1:0] b);
        logic [2*QW-1:0] prod;
        prod = a * b + ((2*QW)'(1) << (FRAC_BITS - 1));
        return prod[FRAC_BITS +: QW];
    endfunction

    logic vld_reg [0:NSTG-1];
    logic adv     [0:NSTG-1];

    // Advance a stage when it is empty or the next one advances
    genvar gi;
    generate
        for (gi = 0; gi < NSTG - 1; gi++) begin : g_adv
            assign adv[gi] = !vld_reg[gi] || adv[gi+1];
        end
    endgenerate
    assign adv[NSTG-1] = !vld_reg[NSTG-1] || out_ready;

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Stage 0: pick the base x = u or ONE - u
    ease_sel_t         sel0_reg, sel1_reg, sel2_reg, sel3_reg;
    logic              low0_reg, low1_reg, low2_reg, low3_reg;
    logic [SIDE_W-1:0] side0_reg, side1_reg, side2_reg, side3_reg, side4_reg;
    logic [QW-1:0]     x0_reg, x1_reg, x2_reg;
    logic [QW-1:0]     p2_1_reg, p2_2_reg, p3_2_reg, p_3_reg;
    logic [QW-1:0]     c4_reg;

    logic              low_next;
    logic              mirror_next;
    logic [QW-1:0]     x_next;

    always_comb
    begin
        low_next    = (in_u < HALF);
        mirror_next = (in_sel.kind == KIND_OUT) || ((in_sel.kind == KIND_BOTH) && !low_next);
        x_next      = mirror_next ? (ONE - in_u) : in_u;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sel0_reg  <= in_sel;
            low0_reg  <= low_next;
            side0_reg <= in_side;
            x0_reg    <= x_next;
        end
    end

    // Stage 1: square
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sel1_reg  <= sel0_reg;
            low1_reg  <= low0_reg;
            side1_reg <= side0_reg;
            x1_reg    <= x0_reg;
            p2_1_reg  <= qmul(x0_reg, x0_reg);
        end
    end

    // Stage 2: cube
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            sel2_reg  <= sel1_reg;
            low2_reg  <= low1_reg;
            side2_reg <= side1_reg;
            x2_reg    <= x1_reg;
            p2_2_reg  <= p2_1_reg;
            p3_2_reg  <= qmul(p2_1_reg, x1_reg);
        end
    end

    // Stage 3: fourth power and select by order
    logic [QW-1:0] p_next;

    always_comb
    begin
        case (sel2_reg.order)
            ORDER_QUAD:  p_next = p2_2_reg;
            ORDER_CUBIC: p_next = p3_2_reg;
            ORDER_QUART: p_next = qmul(p3_2_reg, x2_reg);
            default:     p_next = p2_2_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            sel3_reg  <= sel2_reg;
            low3_reg  <= low2_reg;
            side3_reg <= side2_reg;
            p_3_reg   <= p_next;
        end
    end

    // Stage 4: shape and clamp to [0, ONE]
    logic [SW-1:0] scaled;
    logic [QW-1:0] c_next;

    always_comb
    begin
        case (sel3_reg.order)
            ORDER_QUAD:  scaled = SW'(p_3_reg) << 1;
            ORDER_CUBIC: scaled = SW'(p_3_reg) << 2;
            ORDER_QUART: scaled = SW'(p_3_reg) << 3;
            default:     scaled = SW'(p_3_reg) << 1;
        endcase
        case (sel3_reg.kind)
            KIND_IN:  c_next = p_3_reg;
            KIND_OUT: c_next = ONE - p_3_reg;
            KIND_BOTH:
            begin
                if (low3_reg)
                begin
                    c_next = (scaled > ONE_S) ? ONE : scaled[QW-1:0];
                end
                else
                begin
                    c_next = (scaled >= ONE_S) ? '0 : QW'(ONE_S - scaled);
                end
            end
            default:  c_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            side4_reg <= side3_reg;
            c4_reg    <= c_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_c     = c4_reg;
    assign out_side  = side4_reg;

endmodule

### hw/rtl/ece_scale.sv
// ----------------------------------------------------------------------------
// ece_scale: output scaling
// Multiplies change by the curve value, rounds to nearest and adds the
// start value; the last stage is the output register.
// ----------------------------------------------------------------------------
module ece_scale
#(
    parameter int VALUE_WIDTH = 16,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [FRAC_BITS:0]            in_c,
    input  logic signed [VALUE_WIDTH-1:0] in_start,
    input  logic signed [VALUE_WIDTH-1:0] in_change,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH:0]   out_value
);

    localparam int PW = VALUE_WIDTH + FRAC_BITS + 2;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

    logic                          vld0_reg, vld1_reg;
    logic                          adv0, adv1;
    logic signed [PW-1:0]          prod_reg;
    logic signed [VALUE_WIDTH-1:0] start_reg;
    logic signed [VALUE_WIDTH:0]   value_reg;

    logic signed [PW-1:0]          prod_next;
    logic signed [PW-1:0]          rnd;
    logic signed [PW-1:0]          quo;
    logic signed [VALUE_WIDTH:0]   value_next;

    assign adv1 = !vld1_reg || out_ready;
    assign adv0 = !vld0_reg || adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                vld0_reg <= in_valid;
            end
            if (adv1)
            begin
                vld1_reg <= vld0_reg;
            end
        end
    end

    // Stage 0: signed product change * c
    assign prod_next = PW'(in_change) * $signed({1'b0, in_c});

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            prod_reg  <= prod_next;
            start_reg <= in_start;
        end
    end

    // Stage 1: round half up, drop fraction bits, add start
    always_comb
    begin
        rnd        = prod_reg + HALF_P;
        quo        = rnd >>> FRAC_BITS;
        value_next = (VALUE_WIDTH+1)'(start_reg) + quo[VALUE_WIDTH:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            value_reg <= value_next;
        end
    end

    assign in_ready  = adv0;
    assign out_valid = vld1_reg;
    assign out_value = value_reg;

endmodule

### hw/rtl/easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator: polynomial easing curve evaluator
// Quadratic, cubic and quartic ease-in, ease-out and ease-both curves,
// one eased value per item.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  s_axis   in         tuser: cmd; tdata: elapsed, start_value, change, duration
//  m_axis   out        tdata: eased_value
//
//  One item per cycle sustained while m_axis_tready stays high. There are
//  FRAC_BITS + 1 divider stages (an entry stage, then one quotient bit per
//  stage), five curve stages and two scaling stages, output register last.
//  Reset clears only the valid bits; the pipeline starts empty.
//  A stall on m_axis holds the output; earlier stages keep filling bubbles
//  and s_axis_tready falls only when every stage holds an item.
// ----------------------------------------------------------------------------
module easing_curve_evaluator
    import ece_pkg::*;
#(
    parameter int VALUE_WIDTH = 16,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // cmd [3:0]
    input  logic [CMD_W-1:0]        s_axis_tuser,
    // elapsed, start_value, change, duration, zero fill
    input  logic [((2*TIME_W+2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // eased_value, zero fill
    output logic [((VALUE_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

    localparam int SIDE_W      = 2 * VALUE_WIDTH;
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + 8) / 8) * 8;
    localparam int START_LO    = TIME_W;
    localparam int CHANGE_LO   = TIME_W + VALUE_WIDTH;
    localparam int DUR_LO      = TIME_W + 2 * VALUE_WIDTH;

    logic [TIME_W-1:0]             elapsed;
    logic [TIME_W-1:0]             duration;
    logic [VALUE_WIDTH-1:0]        start_value;
    logic [VALUE_WIDTH-1:0]        change;
    ease_sel_t                     sel;

    logic                          div_valid, div_ready;
    ease_sel_t                     div_sel;
    logic [FRAC_BITS:0]            div_u;
    logic [SIDE_W-1:0]             div_side;

    logic                          crv_valid, crv_ready;
    logic [FRAC_BITS:0]            crv_c;
    logic [SIDE_W-1:0]             crv_side;

    logic signed [VALUE_WIDTH:0]   eased_value;

    // Unpack the input item
    assign elapsed     = s_axis_tdata[TIME_W-1:0];
    assign start_value = s_axis_tdata[START_LO +: VALUE_WIDTH];
    assign change      = s_axis_tdata[CHANGE_LO +: VALUE_WIDTH];
    assign duration    = s_axis_tdata[DUR_LO +: TIME_W];
    assign sel         = decode_cmd(s_axis_tuser);

    ece_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_sel      (sel),
        .in_elapsed  (elapsed),
        .in_duration (duration),
        .in_side     ({change, start_value}),
        .out_valid   (div_valid),
        .out_ready   (div_ready),
        .out_sel     (div_sel),
        .out_u       (div_u),
        .out_side    (div_side)
    );

    ece_curve #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_sel    (div_sel),
        .in_u      (div_u),
        .in_side   (div_side),
        .out_valid (crv_valid),
        .out_ready (crv_ready),
        .out_c     (crv_c),
        .out_side  (crv_side)
    );

    ece_scale #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (crv_valid),
        .in_ready  (crv_ready),
        .in_c      (crv_c),
        .in_start  (crv_side[VALUE_WIDTH-1:0]),
        .in_change (crv_side[SIDE_W-1:VALUE_WIDTH]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (eased_value)
    );

    // Pack the result item
    assign m_axis_tdata = OUT_TDATA_W'(unsigned'(eased_value));

endmodule

### hw/rtl/ece_checker.sv
// ----------------------------------------------------------------------------
// ece_checker: port-level checks for the easing curve evaluator
// Watches both stream channels and the reset; bound to the top level.
// ----------------------------------------------------------------------------
module ece_checker
    import ece_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_axis_tvalid,
    input logic                    s_axis_tready,
    input logic [CMD_W-1:0]        s_axis_tuser,
    input logic [((2*TIME_W+2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [((VALUE_WIDTH+8)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_TDATA_W = ((VALUE_WIDTH + 8) / 8) * 8;

    // No result is shown while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // An offered item holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("waiting input item changed or dropped");

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A free output stage lets the whole pipeline advance
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output is free");

    // Fill bits above the result stay zero
    generate
        if (OUT_TDATA_W > VALUE_WIDTH + 1) begin : g_pad
            a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
                m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:VALUE_WIDTH+1] == '0))
                else $error("nonzero fill bits in result");
        end
    endgenerate

endmodule

bind easing_curve_evaluator ece_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ece_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_easing_curve_evaluator.sv
// ----------------------------------------------------------------------------
// tb_easing_curve_evaluator: self-checking bench for the easing curve evaluator
// Streams curve items through the block with bursty input and a stalling
// output, predicts every eased value in fixed point and compares in order.
// ----------------------------------------------------------------------------
module tb_easing_curve_evaluator;

    timeunit 1ns;
    timeprecision 1ps;

    import ece_pkg::*;

    localparam int VAL_W    = 16;
    localparam int FRAC     = 16;
    localparam int OUT_W    = VAL_W + 1;
    localparam int IN_DW    = ((2*TIME_W+2*VAL_W+7)/8)*8;
    localparam int OUT_DW   = ((VAL_W+8)/8)*8;
    localparam longint UNIT = longint'(1) << FRAC;
    localparam longint HALF_UNIT = longint'(1) << (FRAC - 1);
    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_AT_ITEM = 200;
    localparam int HOLD_CYCLES  = 150;
    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] elapsed;
        logic [VAL_W-1:0]  start_value;
        logic [VAL_W-1:0]  change;
        logic [TIME_W-1:0] duration;
    } curve_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // cmd [3:0]
    logic [CMD_W-1:0] s_axis_tuser = '0;
    // elapsed [15:0], start_value [31:16], change [47:32], duration [63:48]
    logic [IN_DW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // eased_value [16:0], zero fill [23:17]
    logic [OUT_DW-1:0] m_axis_tdata;

    curve_item_t pending_items[$];
    logic signed [OUT_W-1:0] eased_expected[$];
    curve_item_t offered_item = '0;
    logic offer_live = 1'b0;
    logic offer_taken = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int ready_mode = 0;
    int mode_cycles = 0;
    int items_accepted = 0;
    int values_checked = 0;
    int fail_count = 0;
    int undef_count = 0;
    int zero_dur_count = 0;
    int overrun_count = 0;

    easing_curve_evaluator #(
        .VALUE_WIDTH (VAL_W),
        .FRAC_BITS   (FRAC)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Raise x to the given power, rounding each fixed-point product
    function automatic longint raise_q(longint x, int power);
        longint acc;
        acc = x;
        for (int k = 1; k < power; k++)
            acc = (acc * x + HALF_UNIT) >>> FRAC;
        return acc;
    endfunction

    // Expected eased value for one curve item
    function automatic logic signed [OUT_W-1:0] predict_eased(curve_item_t it);
        longint frac;
        longint shape;
        longint scale;
        longint prod;
        longint res;
        longint clipped;
        int power;
        ease_kind_t kind;
        power = 2;
        kind = KIND_OFF;
        case (it.cmd)
            CMD_QUAD_IN:    begin kind = KIND_IN;   power = 2; end
            CMD_QUAD_OUT:   begin kind = KIND_OUT;  power = 2; end
            CMD_QUAD_BOTH:  begin kind = KIND_BOTH; power = 2; end
            CMD_CUBIC_IN:   begin kind = KIND_IN;   power = 3; end
            CMD_CUBIC_OUT:  begin kind = KIND_OUT;  power = 3; end
            CMD_CUBIC_BOTH: begin kind = KIND_BOTH; power = 3; end
            CMD_QUART_IN:   begin kind = KIND_IN;   power = 4; end
            CMD_QUART_OUT:  begin kind = KIND_OUT;  power = 4; end
            CMD_QUART_BOTH: begin kind = KIND_BOTH; power = 4; end
            default:        begin kind = KIND_OFF;  power = 2; end
        endcase

        // Saturate elapsed time, then form the fraction
        if (it.duration == 0)
            frac = UNIT;
        else
        begin
            clipped = (it.elapsed > it.duration) ? longint'(it.duration)
                                                 : longint'(it.elapsed);
            frac = (clipped << FRAC) / longint'(it.duration);
        end

        // Shape the fraction
        scale = longint'(1) << (power - 1);
        case (kind)
            KIND_IN:   shape = raise_q(frac, power);
            KIND_OUT:  shape = UNIT - raise_q(UNIT - frac, power);
            KIND_BOTH:
            begin
                if (frac < HALF_UNIT)
                    shape = scale * raise_q(frac, power);
                else
                    shape = UNIT - scale * raise_q(UNIT - frac, power);
            end
            default:   shape = 0;
        endcase
        if (shape < 0)
            shape = 0;
        if (shape > UNIT)
            shape = UNIT;

        // Scale the change, round to nearest with ties upward
        prod = longint'($signed(it.change)) * shape;
        res = longint'($signed(it.start_value)) + ((prod + HALF_UNIT) >>> FRAC);
        return res[OUT_W-1:0];
    endfunction

    task automatic add_item(input logic [CMD_W-1:0] cmd, input int elapsed,
                            input int start_value, input int change, input int duration);
        curve_item_t it;
        it.cmd = cmd;
        it.elapsed = elapsed[TIME_W-1:0];
        it.start_value = start_value[VAL_W-1:0];
        it.change = change[VAL_W-1:0];
        it.duration = duration[TIME_W-1:0];
        pending_items.push_back(it);
    endtask

    // Input driver: bursts of items with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (offer_live && offer_taken)
                offer_live = 1'b0;
            if (!offer_live)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_items.size() > 0)
                begin
                    offered_item = pending_items.pop_front();
                    offer_live = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            s_axis_tvalid <= offer_live;
            s_axis_tuser <= offered_item.cmd;
            s_axis_tdata <= {offered_item.duration, offered_item.change,
                             offered_item.start_value, offered_item.elapsed};
        end
    end

    // Long hold-off: count it down once enough items have gone in
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && items_accepted >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
        end
    end

    // Output ready: a changing stall pattern, held low during the hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                mode_cycles++;
                if (mode_cycles >= 64)
                begin
                    mode_cycles = 0;
                    ready_mode = $urandom_range(0, 3);
                end
                case (ready_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= (mode_cycles % 5 != 0);
                endcase
            end
        end
    end

    // Record accepted items and predict their results
    always @(posedge clk)
    begin
        if (!rst_n)
            offer_taken <= 1'b0;
        else
        begin
            offer_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                eased_expected.push_back(predict_eased(offered_item));
                items_accepted++;
                if (offered_item.cmd > CMD_QUART_BOTH)
                    undef_count++;
                if (offered_item.duration == 0)
                    zero_dur_count++;
                else if (offered_item.elapsed > offered_item.duration)
                    overrun_count++;
            end
        end
    end

    // Output monitor: compare each result with the oldest prediction
    always @(posedge clk)
    begin
        logic signed [OUT_W-1:0] want;
        logic signed [OUT_W-1:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_W-1:0];
            if (eased_expected.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%t: eased value %0d arrived with nothing pending", $realtime, got);
                fail_count++;
            end
            else
            begin
                want = eased_expected.pop_front();
                values_checked++;
                if (got !== want)
                begin
                    if (fail_count < 10)
                        $display("%t: eased value mismatch, expected %0d, got %0d",
                                 $realtime, want, got);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int dur;
        int el;
        int st;
        int ch;
        logic [CMD_W-1:0] cmd;

        // Each curve below the midpoint, the ease-both curves above it
        for (int c = 0; c <= 8; c++)
            add_item(c[CMD_W-1:0], 'h3000, 100, 20000, 'hA000);
        add_item(CMD_QUAD_BOTH, 'h7000, -500, 30000, 'hA000);
        add_item(CMD_CUBIC_BOTH, 'h7000, -500, -30000, 'hA000);
        add_item(CMD_QUART_BOTH, 'h7000, 0, 32767, 'hA000);
        // Fraction exactly one half
        add_item(CMD_CUBIC_BOTH, 1, 7, 1001, 2);
        // Zero duration with the most negative sum
        add_item(CMD_QUAD_OUT, 123, -32768, -32768, 0);
        // Elapsed past the end with the most positive sum
        add_item(CMD_QUART_IN, 'hFFFF, 32767, 32767, 100);
        // Undefined selectors
        add_item(4'd9, 'h4000, 1234, 5000, 'h8000);
        add_item(4'd15, 'hFFFF, -1, -1, 'hFFFF);
        add_item(4'd12, 0, -32768, 32767, 0);
        // Ends of the time range
        add_item(CMD_QUAD_IN, 0, 0, -32768, 'hFFFF);
        add_item(CMD_QUART_OUT, 'hFFFF, -32768, 32767, 'hFFFF);
        add_item(CMD_CUBIC_IN, 1, 0, 32767, 'hFFFF);
        add_item(CMD_CUBIC_OUT, 'hFFFE, 32767, -32768, 'hFFFF);
        add_item(CMD_QUART_BOTH, 0, 55, 66, 0);

        // Random items, mostly defined curves and in-range time
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cmd = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                               : 4'($urandom_range(9, 15));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: dur = $urandom_range(1, 64);
                4:          dur = 0;
                5:          dur = 'hFFFF;
                default:    dur = $urandom_range(1, 'hFFFF);
            endcase
            case ($urandom_range(0, 19))
                0, 1, 2: el = $urandom_range(0, 'hFFFF);
                3:       el = 'hFFFF;
                default: el = $urandom_range(0, dur);
            endcase
            st = $urandom_range(0, 'hFFFF);
            ch = $urandom_range(0, 'hFFFF);
            if ($urandom_range(0, 9) == 0)
                st = $urandom_range(0, 1) ? 'h7FFF : 'h8000;
            if ($urandom_range(0, 9) == 0)
                ch = $urandom_range(0, 1) ? 'h7FFF : 'h8000;
            add_item(cmd, el, st, ch, dur);
        end

        // Hold reset, then release it on a falling edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain input, then results, then let the pipeline settle
        while (pending_items.size() != 0 || offer_live)
            @(posedge clk);
        while (eased_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d undefined selectors, %0d zero durations, %0d past the end",
                 items_accepted, undef_count, zero_dur_count, overrun_count);
        $display("Checked %0d eased values across all nine curves, %0d failures",
                 values_checked, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", eased_expected.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
